### hw/rtl/smdu_pkg.sv
// Package for the serial multiply/divide unit.
// Holds access kind codes, register offsets and engine constants.
// No dependencies.
package smdu_pkg;

  // Access kind carried on the input tuser
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Write offsets
  localparam logic [4:0] ADDR_MCAND   = 5'h02;
  localparam logic [4:0] ADDR_MPLIER  = 5'h03;
  localparam logic [4:0] ADDR_DIVD_LO = 5'h04;
  localparam logic [4:0] ADDR_DIVD_HI = 5'h05;
  localparam logic [4:0] ADDR_DIVISOR = 5'h06;

  // Read offsets
  localparam logic [4:0] ADDR_QUOT_LO = 5'h14;
  localparam logic [4:0] ADDR_QUOT_HI = 5'h15;
  localparam logic [4:0] ADDR_PR_LO   = 5'h16;
  localparam logic [4:0] ADDR_PR_HI   = 5'h17;

  // Engine step counts and reset values
  localparam logic [3:0]  MUL_STEPS      = 4'd8;
  localparam logic [4:0]  DIV_STEPS      = 5'd16;
  localparam logic [7:0]  MCAND_RESET    = 8'hFF;
  localparam logic [15:0] DIVIDEND_RESET = 16'hFFFF;

endpackage

### hw/rtl/serial_mul_div_unit.sv
// Top level of the serial multiply/divide unit: bus decode, bit-serial
// multiply and restoring divide engines, and the result register.
// Depends on smdu_pkg.
//
// One item (tick, register read or register write) is accepted per clock
// while the result register is empty or being drained, so the unit sustains
// one item per cycle; in_tready drops only when a read or error result
// sits unclaimed in the output register. A multiply takes 8 ticks and a
// divide 16 ticks after the starting write (offset 0x03 or 0x06); reads
// between ticks return the partial product, remainder or quotient. A start
// while an engine is busy is dropped but still clears or loads the
// product/remainder register. Divide by zero yields quotient 0xFFFF with
// the dividend left as remainder. Reads outside 0x14..0x17 and writes
// outside 0x02..0x06 return read_data 0 with bad_address set.
module serial_mul_div_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] reg_addr, [12:5] write_data, [15:13] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  output logic [0:0]  out_tuser   // [0] bad_address
);

  logic [1:0] action;
  logic [4:0] reg_addr;
  logic [7:0] write_data;
  logic       in_fire;

  logic [7:0]  mcand_r,     mcand_nxt;
  logic [15:0] dividend_r,  dividend_nxt;
  logic [15:0] quot_r,      quot_nxt;
  logic [15:0] prem_r,      prem_nxt;
  logic [23:0] oper_r,      oper_nxt;
  logic [3:0]  mul_left_r,  mul_left_nxt;
  logic [4:0]  div_left_r,  div_left_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r,  out_data_nxt;
  logic        out_bad_r,   out_bad_nxt;

  logic        engine_idle;
  logic        res_valid;
  logic [7:0]  res_data;
  logic        res_bad;
  logic [23:0] div_shift;

  assign action     = in_tuser;
  assign reg_addr   = in_tdata[4:0];
  assign write_data = in_tdata[12:5];

  // Accept whenever the result register is free or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign engine_idle = (mul_left_r == '0) && (div_left_r == '0);
  assign div_shift   = oper_r >> 1;

  // Decode the access and compute next engine state
  always_comb begin
    mcand_nxt    = mcand_r;
    dividend_nxt = dividend_r;
    quot_nxt     = quot_r;
    prem_nxt     = prem_r;
    oper_nxt     = oper_r;
    mul_left_nxt = mul_left_r;
    div_left_nxt = div_left_r;
    res_valid    = 1'b0;
    res_data     = '0;
    res_bad      = 1'b0;
    if (in_fire) begin
      case (action)
        smdu_pkg::ACT_TICK: begin
          // Advance whichever engine is busy by one step
          if (mul_left_r != '0) begin
            mul_left_nxt = mul_left_r - 4'd1;
            if (quot_r[0]) begin
              prem_nxt = prem_r + oper_r[15:0];
            end
            oper_nxt = {oper_r[22:0], 1'b0};
            quot_nxt = {1'b0, quot_r[15:1]};
          end else if (div_left_r != '0) begin
            div_left_nxt = div_left_r - 5'd1;
            oper_nxt     = div_shift;
            quot_nxt     = {quot_r[14:0], 1'b0};
            if ({8'd0, prem_r} >= div_shift) begin
              prem_nxt    = prem_r - div_shift[15:0];
              quot_nxt[0] = 1'b1;
            end
          end
        end
        smdu_pkg::ACT_READ: begin
          res_valid = 1'b1;
          case (reg_addr)
            smdu_pkg::ADDR_QUOT_LO: res_data = quot_r[7:0];
            smdu_pkg::ADDR_QUOT_HI: res_data = quot_r[15:8];
            smdu_pkg::ADDR_PR_LO:   res_data = prem_r[7:0];
            smdu_pkg::ADDR_PR_HI:   res_data = prem_r[15:8];
            default:                res_bad  = 1'b1;
          endcase
        end
        smdu_pkg::ACT_WRITE: begin
          case (reg_addr)
            smdu_pkg::ADDR_MCAND: mcand_nxt = write_data;
            smdu_pkg::ADDR_MPLIER: begin
              prem_nxt = '0;
              if (engine_idle) begin
                mul_left_nxt = smdu_pkg::MUL_STEPS;
                quot_nxt     = {write_data, mcand_r};
                oper_nxt     = {16'd0, write_data};
              end
            end
            smdu_pkg::ADDR_DIVD_LO: dividend_nxt[7:0]  = write_data;
            smdu_pkg::ADDR_DIVD_HI: dividend_nxt[15:8] = write_data;
            smdu_pkg::ADDR_DIVISOR: begin
              prem_nxt = dividend_r;
              if (engine_idle) begin
                div_left_nxt = smdu_pkg::DIV_STEPS;
                oper_nxt     = {write_data, 16'd0};
              end
            end
            default: begin
              res_valid = 1'b1;
              res_bad   = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Load a new result or drop the taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_bad_nxt   = out_bad_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
      out_bad_nxt   = res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcand_r     <= smdu_pkg::MCAND_RESET;
      dividend_r  <= smdu_pkg::DIVIDEND_RESET;
      quot_r      <= '0;
      prem_r      <= '0;
      oper_r      <= '0;
      mul_left_r  <= '0;
      div_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mcand_r     <= mcand_nxt;
      dividend_r  <= dividend_nxt;
      quot_r      <= quot_nxt;
      prem_r      <= prem_nxt;
      oper_r      <= oper_nxt;
      mul_left_r  <= mul_left_nxt;
      div_left_r  <= div_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload holds until replaced
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_bad_r;

  // Engines never run together
  a_one_engine: assert property (@(posedge clk) disable iff (!rst_n)
    !((mul_left_r != '0) && (div_left_r != '0)))
    else $error("multiply and divide busy at once");

  // Step counters stay within their lengths
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_left_r <= smdu_pkg::MUL_STEPS) && (div_left_r <= smdu_pkg::DIV_STEPS))
    else $error("step counter out of range");

  // A tick on a busy multiply consumes exactly one step
  a_mul_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (action == smdu_pkg::ACT_TICK) && (mul_left_r != '0))
    |=> (mul_left_r == $past(mul_left_r) - 4'd1))
    else $error("multiply tick did not advance");

  // Error results carry zero data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_data_r == '0))
    else $error("error result with nonzero data");

  // A stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_valid)
    else $error("result register overrun");

endmodule
